/* hdl/adc_median_adaptive_smoother_core_assert.svh */
// Assertion macros for the checker file.
`ifndef ADC_MEDIAN_ADAPTIVE_SMOOTHER_CORE_ASSERT_SVH
`define ADC_MEDIAN_ADAPTIVE_SMOOTHER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define AMAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define AMAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/amas_pkg.sv */
package amas_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int LEVEL_W     = 10;
    localparam int COUNT_W     = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;
    localparam int WINDOW_LEN  = 7;

    localparam int WEIGHT_W     = 7;
    localparam int WEIGHT_SHIFT = 7;

    localparam int DIV3_SUM_W  = LEVEL_W + 2;
    localparam int DIV3_MUL    = 2731;
    localparam int DIV3_SHIFT  = 13;
    localparam int DIV3_PROD_W = DIV3_SHIFT + LEVEL_W;

    typedef logic [LEVEL_W-1:0]  level_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [WEIGHT_W-1:0] weight_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_JUMP_THRESHOLD    = 3'd0,
        REG_FAST_STEPS        = 3'd1,
        REG_MEDIAN_WARM_STEPS = 3'd2,
        REG_NEAR_BAND         = 3'd3,
        REG_MID_BAND          = 3'd4
    } cfg_reg_t;

    localparam level_t RST_JUMP_THRESHOLD    = 10'd50;
    localparam count_t RST_FAST_STEPS        = 4'd6;
    localparam count_t RST_MEDIAN_WARM_STEPS = 4'd6;
    localparam level_t RST_NEAR_BAND         = 10'd5;
    localparam level_t RST_MID_BAND          = 10'd10;

    localparam weight_t W_PREV_MEDIAN = 7'd8;
    localparam weight_t W_IIR_NEW     = 7'd8;
    localparam weight_t W_IIR_OLD     = 7'd112;
    localparam weight_t W_WARM_MED    = 7'd112;
    localparam weight_t W_WARM_OUT    = 7'd8;
    localparam weight_t W_NEAR_MED    = 7'd8;
    localparam weight_t W_NEAR_OUT    = 7'd112;
    localparam weight_t W_MID_MED     = 7'd20;
    localparam weight_t W_MID_OUT     = 7'd100;
    localparam weight_t W_FAR_MED     = 7'd30;
    localparam weight_t W_FAR_OUT     = 7'd90;

endpackage

/* hdl/amas_median.sv */
module amas_median #(
    parameter int WINDOW_LEN = amas_pkg::WINDOW_LEN
) (
    input  amas_pkg::level_t win [WINDOW_LEN],
    output amas_pkg::level_t median
);
    import amas_pkg::*;

    localparam int RANK_W   = $clog2(WINDOW_LEN);
    localparam int MID_RANK = WINDOW_LEN / 2;

    logic [RANK_W-1:0] rank [WINDOW_LEN];

    // rank each entry, ties broken by position
    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW_LEN; j++)
            begin
                if (j < i)
                begin
                    rank[i] = rank[i] + RANK_W'(win[j] <= win[i]);
                end
                else if (j > i)
                begin
                    rank[i] = rank[i] + RANK_W'(win[j] < win[i]);
                end
            end
        end
    end

    always_comb
    begin
        median = '0;
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            if (rank[i] == RANK_W'(MID_RANK))
            begin
                median = median | win[i];
            end
        end
    end

endmodule

/* hdl/adc_median_adaptive_smoother_core.sv */
// One 12-bit sample per clock in, one 10-bit filtered value per sample out, in order.
// A beat accepted on s_axis lands in a one-entry input register; the whole filter step
// (jump test, three-point average or 1/16 IIR, window shift, seven-input rank median and
// the banded output blend) runs combinationally from there into the state and output
// registers, and the output register drives the result onto m_axis. A
// new sample is taken every clock while m_axis keeps up. When m_axis stalls, one more
// sample is held in the input register before s_axis_tready drops. cfg_ready is always
// high and a register write takes effect on the next sample; write only while idle.
module adc_median_adaptive_smoother_core #(
    parameter int WINDOW_LEN = amas_pkg::WINDOW_LEN
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [amas_pkg::S_TDATA_W-1:0]      s_axis_tdata,   // [11:0] adc_sample
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [amas_pkg::M_TDATA_W-1:0]      m_axis_tdata,   // [9:0] filtered_value
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [amas_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [amas_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import amas_pkg::*;

    localparam int BLEND_SUM_W = LEVEL_W + WEIGHT_SHIFT + 1;

    function automatic level_t blend(level_t a, level_t b, level_t c,
                                     weight_t wa, weight_t wc);
        logic [BLEND_SUM_W-1:0] sum;
        sum = BLEND_SUM_W'(wa) * BLEND_SUM_W'(a)
            + BLEND_SUM_W'(W_PREV_MEDIAN) * BLEND_SUM_W'(b)
            + BLEND_SUM_W'(wc) * BLEND_SUM_W'(c);
        return sum[WEIGHT_SHIFT +: LEVEL_W];
    endfunction

    function automatic level_t abs_diff(level_t a, level_t b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    level_t jump_thr_reg;
    count_t fast_steps_reg;
    count_t warm_steps_reg;
    level_t near_band_reg;
    level_t mid_band_reg;

    logic   in_valid_reg, in_valid_next;
    level_t in_level_reg;
    logic   out_valid_reg, out_valid_next;

    level_t smoothed_reg, smoothed_next;
    level_t prev_sample_reg, prev_sample_next;
    level_t output_reg, output_next;
    level_t prev_median_reg, prev_median_next;
    count_t med_count_reg, med_count_next;
    count_t fast_count_reg, fast_count_next;
    level_t window_reg [WINDOW_LEN];
    level_t window_next [WINDOW_LEN];

    logic   s_beat;
    logic   fire;
    logic   jump;
    level_t cur;
    level_t pm_mid;
    level_t out_mid;
    count_t mc_mid;
    level_t median;
    level_t med_gap;
    logic [DIV3_SUM_W-1:0]  div3_sum;
    logic [DIV3_PROD_W-1:0] div3_prod;

    assign cfg_ready     = 1'b1;
    assign s_beat        = s_axis_tvalid && s_axis_tready;
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(output_reg);

    assign in_valid_next  = s_beat ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    assign cur       = in_level_reg;
    assign jump      = abs_diff(smoothed_reg, cur) > jump_thr_reg;
    assign div3_sum  = DIV3_SUM_W'(smoothed_reg) + DIV3_SUM_W'(prev_sample_reg)
                     + DIV3_SUM_W'(cur);
    assign div3_prod = DIV3_PROD_W'(div3_sum) * DIV3_PROD_W'(DIV3_MUL);

    always_comb
    begin
        prev_sample_next = cur;
        fast_count_next  = fast_count_reg;
        smoothed_next    = smoothed_reg;
        pm_mid           = prev_median_reg;
        out_mid          = output_reg;
        mc_mid           = med_count_reg;
        if (jump)
        begin
            smoothed_next   = cur;
            fast_count_next = '0;
            pm_mid          = cur;
            out_mid         = cur;
            mc_mid          = '0;
        end
        else if (fast_count_reg < fast_steps_reg)
        begin
            fast_count_next = fast_count_reg + 4'd1;
            smoothed_next   = div3_prod[DIV3_SHIFT +: LEVEL_W];
            pm_mid          = smoothed_next;
            out_mid         = smoothed_next;
            mc_mid          = '0;
        end
        else
        begin
            smoothed_next = blend(cur, prev_sample_reg, smoothed_reg, W_IIR_NEW, W_IIR_OLD);
        end
    end

    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN - 1; i++)
        begin
            window_next[i] = jump ? cur : window_reg[i + 1];
        end
        window_next[WINDOW_LEN - 1] = smoothed_next;
    end

    amas_median #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_median (
        .win    (window_next),
        .median (median)
    );

    assign med_gap = abs_diff(median, out_mid);

    always_comb
    begin
        prev_median_next = median;
        med_count_next   = mc_mid;
        if (mc_mid < warm_steps_reg)
        begin
            output_next    = blend(median, pm_mid, out_mid, W_WARM_MED, W_WARM_OUT);
            med_count_next = mc_mid + 4'd1;
        end
        else if (med_gap < near_band_reg)
        begin
            output_next = blend(median, pm_mid, out_mid, W_NEAR_MED, W_NEAR_OUT);
        end
        else if (med_gap < mid_band_reg)
        begin
            output_next = blend(median, pm_mid, out_mid, W_MID_MED, W_MID_OUT);
        end
        else
        begin
            output_next = blend(median, pm_mid, out_mid, W_FAR_MED, W_FAR_OUT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jump_thr_reg   <= RST_JUMP_THRESHOLD;
            fast_steps_reg <= RST_FAST_STEPS;
            warm_steps_reg <= RST_MEDIAN_WARM_STEPS;
            near_band_reg  <= RST_NEAR_BAND;
            mid_band_reg   <= RST_MID_BAND;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_JUMP_THRESHOLD:    jump_thr_reg   <= cfg_data[LEVEL_W-1:0];
                REG_FAST_STEPS:        fast_steps_reg <= cfg_data[COUNT_W-1:0];
                REG_MEDIAN_WARM_STEPS: warm_steps_reg <= cfg_data[COUNT_W-1:0];
                REG_NEAR_BAND:         near_band_reg  <= cfg_data[LEVEL_W-1:0];
                REG_MID_BAND:          mid_band_reg   <= cfg_data[LEVEL_W-1:0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_beat)
        begin
            in_level_reg <= s_axis_tdata[SAMPLE_W-1 -: LEVEL_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothed_reg    <= '0;
            prev_sample_reg <= '0;
            output_reg      <= '0;
            prev_median_reg <= '0;
            med_count_reg   <= '0;
            fast_count_reg  <= '0;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            smoothed_reg    <= smoothed_next;
            prev_sample_reg <= prev_sample_next;
            output_reg      <= output_next;
            prev_median_reg <= prev_median_next;
            med_count_reg   <= med_count_next;
            fast_count_reg  <= fast_count_next;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                window_reg[i] <= window_next[i];
            end
        end
    end

endmodule

/* hdl/amas_checker.sv */
`include "adc_median_adaptive_smoother_core_assert.svh"

module amas_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [amas_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import amas_pkg::*;

    `AMAS_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[M_TDATA_W-1:LEVEL_W] == '0, "result beat has nonzero pad bits")
    `AMAS_ASSERT_NOW(a_stall_only_on_backpressure, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled while output is free")
    `AMAS_ASSERT_NEXT(a_result_follows, s_axis_tvalid && s_axis_tready, ##1 m_axis_tvalid, "no result two cycles after a sample beat")
    `AMAS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result beat changed")

endmodule

bind adc_median_adaptive_smoother_core amas_checker u_amas_checker (.*);
